### rtl/core/scfl_pkg.sv
// Shared types and constants for the size-class free-list allocator.
package scfl_pkg;

    localparam int ADDR_W = 15;
    localparam int LINK_W = 16;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_LARGE = 2'd1;
    localparam logic [1:0] ST_POOL  = 2'd2;
    localparam logic [1:0] ST_ZERO  = 2'd3;

    // Request kinds.
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [15:0] size_bytes;
        logic [14:0] block_address;
    } t_in_item;

    typedef struct packed {
        logic [14:0] result_address;
        logic [1:0]  status;
        logic        collect_request;
        logic [6:0]  pages_in_use;
    } t_out_item;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;       // capture the input item and decode it
        logic do_free;    // push the block on its class list
        logic take_page;  // start a page: countdown and carve setup
        logic carve;      // write one link of the carved chain
        logic pop_rd;     // read the link of the list head
        logic pop_wr;     // move the head to the next block
        logic emit;       // load the output register
        logic [1:0] status;
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic zero_size;
        logic too_big;
        logic is_free;
        logic head_valid;
        logic pool_empty;
        logic carve_last;
    } t_sts;

endpackage

### rtl/core/scfl_ctrl.sv
// Controller state machine of the size-class free-list allocator.
module scfl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_out_full,
    input  scfl_pkg::t_sts i_sts,
    output scfl_pkg::t_cmd o_cmd
);
    import scfl_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_CARVE = 3'd2;
    localparam logic [2:0] S_POPRD = 3'd3;
    localparam logic [2:0] S_POPWR = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0] r_state, n_state;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                if (i_sts.zero_size) begin
                    o_cmd.status = ST_ZERO;
                    n_state = S_EMIT;
                end else if (i_sts.too_big) begin
                    o_cmd.status = ST_LARGE;
                    n_state = S_EMIT;
                end else if (i_sts.is_free) begin
                    o_cmd.do_free = 1'b1;
                    o_cmd.status = ST_OK;
                    n_state = S_EMIT;
                end else if (i_sts.head_valid) begin
                    n_state = S_POPRD;
                end else if (i_sts.pool_empty) begin
                    o_cmd.status = ST_POOL;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.take_page = 1'b1;
                    n_state = S_CARVE;
                end
            end
            S_CARVE: begin
                o_cmd.carve = 1'b1;
                if (i_sts.carve_last) begin
                    n_state = S_POPRD;
                end
            end
            S_POPRD: begin
                o_cmd.pop_rd = 1'b1;
                n_state = S_POPWR;
            end
            S_POPWR: begin
                o_cmd.pop_wr = 1'b1;
                o_cmd.status = ST_OK;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!i_out_full) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef NO_ASSERTIONS
    // Input is only taken when idle.
    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall) else $error("accept while busy");
    // A carve step follows a page take.
    a_take_carve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.take_page |=> (r_state == S_CARVE)) else $error("no carve");
    // Pop read is followed by pop write.
    a_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.pop_rd |=> o_cmd.pop_wr) else $error("pop split");
`endif
endmodule

### rtl/core/scfl_dp.sv
// Datapath of the size-class free-list allocator: link memory, heads, page pool.
module scfl_dp #(
    parameter int WORD_BYTES   = 8,
    parameter int SIZE_CLASSES = 16,
    parameter int PAGE_WORDS   = 512,
    parameter int POOL_PAGES   = 64,
    parameter int HEADER_WORDS = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  scfl_pkg::t_in_item  i_item,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_data,
    input  scfl_pkg::t_cmd      i_cmd,
    output scfl_pkg::t_sts      o_sts,
    output scfl_pkg::t_out_item o_res
);
    import scfl_pkg::*;

    localparam int CLS_W    = $clog2(SIZE_CLASSES + 1);
    localparam int HEAD_IW  = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
    localparam int PG_W     = $clog2(POOL_PAGES + 1);
    localparam int BLK_W    = $clog2(PAGE_WORDS + 1);
    localparam int AVAIL    = PAGE_WORDS - HEADER_WORDS;
    localparam logic [31:0] PAGE_BYTES = 32'(PAGE_WORDS * WORD_BYTES);
    localparam logic [31:0] CD_RESET   = 32'd4194304;

    // Stored state.
    logic [LINK_W-1:0] r_link [0:(1<<ADDR_W)-1];
    logic [LINK_W-1:0] r_heads [0:SIZE_CLASSES-1];
    logic [SIZE_CLASSES-1:0] r_hvalid;
    logic [PG_W-1:0]   r_next_page;
    logic [31:0]       r_countdown;

    // Item registers.
    logic              r_kind;
    logic [15:0]       r_size;
    logic [ADDR_W-1:0] r_addr;
    logic [CLS_W-1:0]  r_cls;
    logic [HEAD_IW-1:0] r_hidx;
    logic              r_collect;
    logic [ADDR_W-1:0] r_here;
    logic [BLK_W-1:0]  r_left;
    logic [LINK_W-1:0] r_rd;
    logic [ADDR_W-1:0] r_res_addr;
    t_out_item         r_out;

    logic [CLS_W-1:0]  cls;
    logic [LINK_W-1:0] head;
    logic [BLK_W-1:0]  nblk;
    logic [BLK_W-1:0]  nblk_tab [0:SIZE_CLASSES-1];

    // Size class of the incoming item: the byte count rounded up to words,
    // found by comparing against each class's upper byte bound.
    always_comb begin
        cls = '0;
        for (int k = 0; k < SIZE_CLASSES; k++) begin
            if (32'(i_item.size_bytes) > 32'(k * WORD_BYTES)) cls = CLS_W'(k + 1);
        end
    end
    assign head = r_hvalid[r_hidx] ? r_heads[r_hidx] : '0;

    // Block count per page from a constant table.
    assign nblk_tab[0] = '0;
    for (genvar g = 1; g < SIZE_CLASSES; g++) begin : g_nblk
        localparam int NB = AVAIL / g;
        assign nblk_tab[g] = BLK_W'(NB);
    end
    assign nblk = nblk_tab[r_hidx];

    always_comb begin
        o_sts.zero_size  = (r_size == 16'd0);
        o_sts.too_big    = (32'(r_cls) >= 32'(SIZE_CLASSES)) || (32'(r_cls) > 32'(AVAIL));
        o_sts.is_free    = (r_kind == KIND_FREE);
        o_sts.head_valid = head[LINK_W-1];
        o_sts.pool_empty = (32'(r_next_page) >= 32'(POOL_PAGES));
        o_sts.carve_last = (r_left == BLK_W'(1));
    end

    // Item capture and decode.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_item.kind;
            r_size <= i_item.size_bytes;
            r_addr <= i_item.block_address;
            r_cls  <= cls;
            r_hidx <= HEAD_IW'(cls);
        end
    end

    // Link memory: one write port, one registered read port at the list head.
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_free) begin
            r_link[r_addr] <= head;
        end else if (i_cmd.carve) begin
            r_link[r_here] <= (r_left == BLK_W'(1)) ? head
                : {1'b1, ADDR_W'(r_here + ADDR_W'(r_cls))};
        end
        r_rd <= r_link[head[ADDR_W-1:0]];
    end

    // Carve walk and popped address.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_page) begin
            r_here <= ADDR_W'(32'(r_next_page) * 32'(PAGE_WORDS) + 32'(HEADER_WORDS));
            r_left <= nblk;
        end else if (i_cmd.carve) begin
            r_here <= ADDR_W'(r_here + ADDR_W'(r_cls));
            r_left <= r_left - BLK_W'(1);
        end
        if (i_cmd.pop_rd) r_res_addr <= head[ADDR_W-1:0];
    end

    // Heads, page counter, countdown and collect flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hvalid    <= '0;
            r_next_page <= '0;
            r_countdown <= CD_RESET;
            r_collect   <= 1'b0;
        end else begin
            if (i_cmd.load) r_collect <= 1'b0;
            if (i_cfg_we) r_countdown <= i_cfg_data;
            if (i_cmd.do_free) begin
                r_heads[r_hidx]  <= {1'b1, r_addr};
                r_hvalid[r_hidx] <= 1'b1;
            end
            if (i_cmd.take_page) begin
                r_next_page <= r_next_page + PG_W'(1);
                if (r_countdown >= PAGE_BYTES) begin
                    r_countdown <= r_countdown - PAGE_BYTES;
                end else begin
                    r_countdown <= '0;
                    r_collect   <= 1'b1;
                end
            end
            if (i_cmd.carve && r_left == BLK_W'(1)) begin
                r_heads[r_hidx] <= {1'b1, ADDR_W'(32'(r_next_page - PG_W'(1))
                    * 32'(PAGE_WORDS) + 32'(HEADER_WORDS))};
                r_hvalid[r_hidx] <= 1'b1;
            end
            if (i_cmd.pop_wr) begin
                r_heads[r_hidx] <= r_rd;
            end
        end
    end

    // Result register, loaded when the status is settled.
    logic [1:0] r_status;
    always_ff @(posedge i_clk) begin
        if (i_cmd.pop_wr || i_cmd.do_free || (|i_cmd.status)) r_status <= i_cmd.status;
        if (i_cmd.emit) begin
            r_out.result_address  <= (r_status == ST_OK && r_kind == KIND_ALLOC)
                                     ? r_res_addr : '0;
            r_out.status          <= r_status;
            r_out.collect_request <= (r_status == ST_OK) && r_collect;
            r_out.pages_in_use    <= 7'(r_next_page);
        end
    end
    assign o_res = r_out;

`ifndef NO_ASSERTIONS
    a_pages: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_next_page) <= 32'(POOL_PAGES)) else $error("pool overrun");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take_page |=> (r_next_page == $past(r_next_page) + PG_W'(1)))
        else $error("page count");
    a_carve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.carve |-> (r_left != '0)) else $error("carve underrun");
`endif
endmodule

### rtl/core/size_class_free_list_allocator.sv
// Top level of the size-class free-list allocator.
// Usage:
// The input channel takes one item (allocate or free) when i_in_valid is high
// and o_in_stall is low. Each item yields exactly one result on the output
// channel, held in an output register until i_out_stall is low.
// An item with a nonempty list goes from accept to result through decode,
// link read, head update and result load. An allocate that finds its list
// empty first takes a page and carves it, one link memory write per block,
// before the link read; the single link write port sets the carve length.
// Frees, zero-size, large and out-of-pages items load the result after decode.
// One item is in flight at a time; the next is accepted in the cycle after
// the result is loaded.
// At reset the class lists are empty, the page counter is zero and the byte
// countdown is 4194304. Writing i_cfg_we reloads the countdown.
// While the receiver stalls, the result stays; a new item can still be taken, but its result waits.
module size_class_free_list_allocator #(
    parameter int WORD_BYTES   = 8,
    parameter int SIZE_CLASSES = 16,
    parameter int PAGE_WORDS   = 512,
    parameter int POOL_PAGES   = 64,
    parameter int HEADER_WORDS = 1
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  scfl_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output scfl_pkg::t_out_item o_out_item,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_data
);
    import scfl_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic r_out_valid;

    scfl_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall), .i_out_full(r_out_valid && i_out_stall),
        .i_sts(sts), .o_cmd(cmd)
    );

    scfl_dp #(
        .WORD_BYTES(WORD_BYTES), .SIZE_CLASSES(SIZE_CLASSES),
        .PAGE_WORDS(PAGE_WORDS), .POOL_PAGES(POOL_PAGES),
        .HEADER_WORDS(HEADER_WORDS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(i_in_item),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_cmd(cmd), .o_sts(sts), .o_res(o_out_item)
    );

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end
    assign o_out_valid = r_out_valid;

`ifndef NO_ASSERTIONS
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("stalled result changed");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_in_stall && i_in_valid) |=> o_in_stall) else $error("double accept");
    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> !(o_out_valid && i_out_stall)) else $error("overwrite");
`endif
endmodule

### dv/tb_top.sv
// Self-checking testbench for the size-class free-list allocator.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import scfl_pkg::*;

    localparam int WORD_BYTES   = 8;
    localparam int SIZE_CLASSES = 16;
    localparam int PAGE_WORDS   = 512;
    localparam int POOL_PAGES   = 64;
    localparam int HEADER_WORDS = 1;
    localparam int PAGE_BYTES   = PAGE_WORDS * WORD_BYTES;
    localparam int PHASE_ITEMS  = 380;
    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic        kind;
        logic [15:0] size;
        logic [14:0] addr;
        bit          typed;
        logic [14:0] exp_addr;
        logic [1:0]  exp_status;
    } t_row;

    typedef struct packed {
        logic [14:0] addr;
        logic [4:0]  cls;
    } t_block;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_item;
    logic        i_cfg_we = 1'b0;
    logic [31:0] i_cfg_data = '0;

    // Shadow state of the allocator.
    logic [15:0] link_mem [0:32767];
    logic [15:0] class_head [0:SIZE_CLASSES-1];
    int unsigned pages_taken;
    logic [31:0] page_budget;

    t_out_item   results_due [$];
    t_block      live_blocks [$];
    t_in_item    pending_items [$];
    int          errors = 0;
    int          quiet_cycles = 0;
    bit          calm = 1'b0;
    bit          hold_req = 1'b0;

    size_class_free_list_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Work out the result of one item and update the shadow state.
    function automatic t_out_item allocate_or_free(t_in_item it);
        t_out_item   r;
        int unsigned cls;
        int unsigned nblk;
        int unsigned base;
        logic [15:0] hd;
        bit          pop;
        r = '0;
        r.status = ST_OK;
        pop = 1'b0;
        cls = (int'(it.size_bytes) + WORD_BYTES - 1) / WORD_BYTES;
        nblk = (cls == 0) ? 0 : (PAGE_WORDS - HEADER_WORDS) / cls;
        if (it.size_bytes == 0) begin
            r.status = ST_ZERO;
        end else if (cls >= SIZE_CLASSES || nblk == 0) begin
            r.status = ST_LARGE;
        end else if (it.kind == KIND_FREE) begin
            link_mem[it.block_address] = class_head[cls];
            class_head[cls] = {1'b1, it.block_address};
        end else if (!class_head[cls][15] && pages_taken >= POOL_PAGES) begin
            r.status = ST_POOL;
        end else begin
            pop = 1'b1;
            if (!class_head[cls][15]) begin
                if (page_budget >= PAGE_BYTES) begin
                    page_budget = page_budget - PAGE_BYTES;
                end else begin
                    page_budget = '0;
                    r.collect_request = 1'b1;
                end
                // Chain the page's blocks in ascending order onto the empty list.
                base = pages_taken * PAGE_WORDS + HEADER_WORDS;
                for (int unsigned i = 0; i < nblk; i++) begin
                    if (i + 1 < nblk)
                        link_mem[(base + i * cls) & 32'h7FFF] =
                            {1'b1, 15'((base + (i + 1) * cls) & 32'h7FFF)};
                    else
                        link_mem[(base + i * cls) & 32'h7FFF] = class_head[cls];
                end
                class_head[cls] = {1'b1, 15'(base & 32'h7FFF)};
                pages_taken++;
            end
        end
        if (pop) begin
            hd = class_head[cls];
            class_head[cls] = link_mem[hd[14:0]];
            r.result_address = hd[14:0];
        end
        r.pages_in_use = pages_taken[6:0];
        return r;
    endfunction

    // Offer one item, hold it until accepted, and record its expected result.
    task automatic send_item(t_in_item it, bit typed, logic [14:0] ea, logic [1:0] es);
        t_out_item r;
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (o_in_stall);
        r = allocate_or_free(it);
        if (typed) begin
            r.result_address = ea;
            r.status = es;
        end
        if (it.kind == KIND_ALLOC && r.status == ST_OK)
            live_blocks.push_back({r.result_address,
                5'((int'(it.size_bytes) + WORD_BYTES - 1) / WORD_BYTES)});
        results_due.push_back(r);
        if (!calm && $urandom_range(5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
    endtask

    // Wait until every expected result is back and the block is quiet.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_budget(logic [31:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        page_budget = value;
    endtask

    function automatic logic [15:0] size_of_class(int unsigned cls);
        return 16'($urandom_range((cls - 1) * WORD_BYTES + 1, cls * WORD_BYTES));
    endfunction

    // Cut a list short: free its head into an empty list, then pop it from both,
    // so that the next allocate of the class takes a fresh page.
    function automatic void queue_page_grab();
        int unsigned c;
        int unsigned d;
        t_in_item    it;
        c = $urandom_range(1, SIZE_CLASSES - 1);
        d = 0;
        for (int unsigned k = 1; k < SIZE_CLASSES; k++)
            if (k != c && !class_head[k][15]) d = k;
        it.kind = KIND_ALLOC;
        it.block_address = 15'($urandom);
        it.size_bytes = size_of_class(c);
        if (class_head[c][15] && d != 0) begin
            pending_items.push_back({KIND_FREE, size_of_class(d), class_head[c][14:0]});
            pending_items.push_back({KIND_ALLOC, size_of_class(d), 15'($urandom)});
            pending_items.push_back(it);
        end
        pending_items.push_back(it);
    endfunction

    // Pick the next random item; grab_pct sets how often pages are forced out.
    function automatic t_in_item next_random(int unsigned grab_pct);
        t_in_item    it;
        int unsigned pick;
        int unsigned idx;
        if (pending_items.size() == 0 && $urandom_range(99) < grab_pct)
            queue_page_grab();
        if (pending_items.size() != 0)
            return pending_items.pop_front();
        it = t_in_item'($urandom);
        pick = $urandom_range(99);
        if (pick < 3) begin
            it.size_bytes = '0;
        end else if (pick < 8) begin
            it.size_bytes = 16'($urandom_range(121, 65535));
        end else if (pick < 12) begin
            // Fully random item.
        end else if (pick < 15) begin
            it.kind = KIND_FREE;
            it.size_bytes = size_of_class($urandom_range(1, SIZE_CLASSES - 1));
        end else if (pick < 55 || live_blocks.size() == 0) begin
            it.kind = KIND_ALLOC;
            it.size_bytes = size_of_class($urandom_range(1, SIZE_CLASSES - 1));
        end else begin
            idx = $urandom_range(live_blocks.size() - 1);
            it.kind = KIND_FREE;
            it.block_address = live_blocks[idx].addr;
            it.size_bytes = size_of_class(live_blocks[idx].cls);
            live_blocks.delete(idx);
        end
        return it;
    endfunction

    // Output side: random stall bursts and one long hold-off.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(9) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (results_due.size() == 0) begin
                $display("%0t: result with nothing expected, actual %p", $time, o_out_item);
                errors++;
            end else begin
                want = results_due.pop_front();
                if (want.result_address !== o_out_item.result_address) begin
                    $display("%0t: result_address expected %0d actual %0d", $time,
                             want.result_address, o_out_item.result_address);
                    errors++;
                end
                if (want.status !== o_out_item.status) begin
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, o_out_item.status);
                    errors++;
                end
                if (want.collect_request !== o_out_item.collect_request) begin
                    $display("%0t: collect_request expected %0d actual %0d", $time,
                             want.collect_request, o_out_item.collect_request);
                    errors++;
                end
                if (want.pages_in_use !== o_out_item.pages_in_use) begin
                    $display("%0t: pages_in_use expected %0d actual %0d", $time,
                             want.pages_in_use, o_out_item.pages_in_use);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any accepted item or result.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Main sequence: reset, directed rows, then random phases at several budgets.
    initial begin
        t_row directed [] = '{
            '{KIND_ALLOC, 16'd0,     15'h7FFF, 1'b1, 15'd0,     ST_ZERO},
            '{KIND_FREE,  16'd0,     15'h7FFF, 1'b1, 15'd0,     ST_ZERO},
            '{KIND_ALLOC, 16'hFFFF,  15'h0000, 1'b1, 15'd0,     ST_LARGE},
            '{KIND_FREE,  16'hFFFF,  15'h7FFF, 1'b1, 15'd0,     ST_LARGE},
            '{KIND_ALLOC, 16'd121,   15'h0000, 1'b1, 15'd0,     ST_LARGE},
            '{KIND_ALLOC, 16'd120,   15'h7FFF, 1'b1, 15'd1,     ST_OK},
            '{KIND_ALLOC, 16'd1,     15'h0000, 1'b1, 15'd513,   ST_OK},
            '{KIND_ALLOC, 16'd8,     15'h0000, 1'b1, 15'd514,   ST_OK},
            '{KIND_FREE,  16'd8,     15'd513,  1'b1, 15'd0,     ST_OK},
            '{KIND_ALLOC, 16'd5,     15'h0000, 1'b1, 15'd513,   ST_OK},
            '{KIND_FREE,  16'd16,    15'h7FFF, 1'b1, 15'd0,     ST_OK},
            '{KIND_ALLOC, 16'd9,     15'h0000, 1'b1, 15'h7FFF,  ST_OK},
            '{KIND_ALLOC, 16'd16,    15'h0000, 1'b0, 15'd0,     ST_OK},
            '{KIND_ALLOC, 16'd113,   15'h0000, 1'b1, 15'd16,    ST_OK},
            '{KIND_FREE,  16'd64,    15'h0000, 1'b1, 15'd0,     ST_OK},
            '{KIND_ALLOC, 16'd57,    15'h0000, 1'b1, 15'd0,     ST_OK},
            '{KIND_ALLOC, 16'd64,    15'h0000, 1'b0, 15'd0,     ST_OK},
            '{KIND_FREE,  16'd1,     15'h5555, 1'b1, 15'd0,     ST_OK},
            '{KIND_ALLOC, 16'd2,     15'h2AAA, 1'b1, 15'h5555,  ST_OK},
            '{KIND_ALLOC, 16'hAAAA,  15'h2AAA, 1'b1, 15'd0,     ST_LARGE},
            '{KIND_FREE,  16'h5555,  15'h5555, 1'b1, 15'd0,     ST_LARGE}
        };
        logic [31:0] budgets [] = '{32'd0, 32'(2 * PAGE_BYTES + 7), 32'hFFFF_FFFF,
                                    32'(PAGE_BYTES - 1)};
        for (int i = 0; i < 32768; i++) link_mem[i] = '0;
        for (int i = 0; i < SIZE_CLASSES; i++) class_head[i] = '0;
        pages_taken = 0;
        page_budget = 32'd4194304;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i])
            send_item({directed[i].kind, directed[i].size, directed[i].addr},
                      directed[i].typed, directed[i].exp_addr, directed[i].exp_status);
        drain();

        // One random phase at the reset budget, then one after each new budget.
        for (int ph = 0; ph <= budgets.size(); ph++) begin
            if (ph > 0) begin
                drain();
                write_budget(budgets[ph - 1]);
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 1 && n == 20) hold_req = 1'b1;
                if (ph == budgets.size() && n == PHASE_ITEMS - 150) calm = 1'b1;
                send_item(next_random(ph * 8), 1'b0, '0, ST_OK);
            end
        end
        drain();
        repeat (20) @(posedge i_clk);

        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
